// ===== src/sfla_pkg.sv =====
// Shared types, codes and sizes for the slot free-list allocator.
package sfla_pkg;

  localparam int NUM_SLOTS    = 256;
  localparam int SLOT_BITS    = $clog2(NUM_SLOTS);
  localparam int COUNT_BITS   = SLOT_BITS + 1;
  localparam int PAYLOAD_BITS = 32;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_QUERY = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOT_USED = 2'd2,
    STAT_RANGE    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_t;

  // One free-list link: fresh means the target is the head of the untouched
  // initial chain, ok means the link exists at all.
  typedef struct packed {
    logic                 fresh;
    logic                 ok;
    logic [SLOT_BITS-1:0] idx;
  } link_t;

  typedef struct packed {
    logic issue;   // capture the request and launch the memory reads
    logic commit;  // apply the request and load the response register
  } cmd_t;

  typedef struct packed {
    logic rsp_free;  // response register can take a new transaction
  } sts_t;

endpackage

// ===== src/sfla_ctrl.sv =====
// Controller state machine of the slot free-list allocator.
module sfla_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  sfla_pkg::sts_t sts,
  output sfla_pkg::cmd_t cmd
);
  import sfla_pkg::*;

  fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall  = 1'b1;
    cmd.issue  = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        cmd.issue = req_valid;
      end
      S_EXEC: begin
        cmd.commit = sts.rsp_free;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/sfla_datapath.sv =====
// Datapath of the slot free-list allocator: slot state, list memories, response register.
module sfla_datapath #(
  parameter int PAYLOAD_BITS = sfla_pkg::PAYLOAD_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           active_slots_we,
  input  logic [sfla_pkg::COUNT_BITS-1:0] active_slots_wdata,
  input  logic [1:0]                     req_type,
  input  logic [sfla_pkg::SLOT_BITS-1:0] slot_index,
  input  logic [PAYLOAD_BITS-1:0]        payload,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [1:0]                     status,
  output logic [sfla_pkg::SLOT_BITS-1:0] slot_index_out,
  output logic [PAYLOAD_BITS-1:0]        payload_out,
  output logic                           slot_used,
  output logic                           table_full,
  input  sfla_pkg::cmd_t                 cmd,
  output sfla_pkg::sts_t                 sts
);
  import sfla_pkg::*;

  // Slot state.
  logic [COUNT_BITS-1:0]   active_slots;
  logic [SLOT_BITS-1:0]    head;
  logic                    head_ok;
  logic                    head_fresh;
  logic [NUM_SLOTS-1:0]    used_mark;
  link_t                   link_mem [NUM_SLOTS];
  logic [PAYLOAD_BITS-1:0] pay_mem  [NUM_SLOTS];

  // Captured request and registered read data.
  req_t                    rq_type;
  logic [SLOT_BITS-1:0]    rq_index;
  logic [PAYLOAD_BITS-1:0] rq_payload;
  link_t                   link_rd;
  logic [PAYLOAD_BITS-1:0] pay_rd;
  logic                    used_rd;

  // Next-state and result values for a commit.
  logic [SLOT_BITS-1:0]    head_next;
  logic                    head_ok_next;
  logic                    head_fresh_next;
  logic [COUNT_BITS-1:0]   head_inc;
  logic                    in_range;
  logic                    used_we;
  logic                    used_val;
  logic [SLOT_BITS-1:0]    used_addr;
  logic                    link_we;
  logic                    pay_we;
  status_t                 res_status;
  logic [SLOT_BITS-1:0]    res_index;
  logic [PAYLOAD_BITS-1:0] res_payload;
  logic                    res_used;
  logic [COUNT_BITS-1:0]   wr_clamped;

  assign sts.rsp_free = !rsp_valid || !rsp_stall;

  always_comb begin
    if (active_slots_wdata == '0) begin
      wr_clamped = COUNT_BITS'(1);
    end else if (active_slots_wdata > COUNT_BITS'(NUM_SLOTS)) begin
      wr_clamped = COUNT_BITS'(NUM_SLOTS);
    end else begin
      wr_clamped = active_slots_wdata;
    end
  end

  assign head_inc = {1'b0, head} + COUNT_BITS'(1);
  assign in_range = {1'b0, rq_index} < active_slots;

  always_comb begin
    head_next       = head;
    head_ok_next    = head_ok;
    head_fresh_next = head_fresh;
    used_we         = 1'b0;
    used_val        = 1'b0;
    used_addr       = rq_index;
    link_we         = 1'b0;
    pay_we          = 1'b0;
    res_status      = STAT_OK;
    res_index       = rq_index;
    res_payload     = '0;
    res_used        = 1'b0;
    case (rq_type)
      REQ_ALLOC: begin
        if (!head_ok) begin
          res_status = STAT_FULL;
        end else begin
          used_we   = 1'b1;
          used_val  = 1'b1;
          used_addr = head;
          pay_we    = 1'b1;
          res_index = head;
          res_used  = 1'b1;
          if (head_fresh) begin
            head_next       = head_inc[SLOT_BITS-1:0];
            head_ok_next    = head_inc < active_slots;
            head_fresh_next = 1'b1;
          end else begin
            head_next       = link_rd.idx;
            head_ok_next    = link_rd.ok;
            head_fresh_next = link_rd.fresh;
          end
        end
      end
      REQ_FREE: begin
        if (!in_range) begin
          res_status = STAT_RANGE;
        end else if (!used_rd) begin
          res_status = STAT_NOT_USED;
        end else begin
          used_we         = 1'b1;
          link_we         = 1'b1;
          head_next       = rq_index;
          head_ok_next    = 1'b1;
          head_fresh_next = 1'b0;
        end
      end
      REQ_READ: begin
        if (!in_range) begin
          res_status = STAT_RANGE;
        end else begin
          res_used    = used_rd;
          res_payload = used_rd ? pay_rd : '0;
        end
      end
      REQ_QUERY: begin
        if (!in_range) begin
          res_status = STAT_RANGE;
        end else begin
          res_used = used_rd;
        end
      end
      default: res_status = STAT_OK;
    endcase
  end

  // Control state: list head, used marks and size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= COUNT_BITS'(NUM_SLOTS);
      head         <= '0;
      head_ok      <= 1'b1;
      head_fresh   <= 1'b1;
      used_mark    <= '0;
    end else if (active_slots_we) begin
      active_slots <= wr_clamped;
      head         <= '0;
      head_ok      <= 1'b1;
      head_fresh   <= 1'b1;
      used_mark    <= '0;
    end else if (cmd.commit) begin
      head       <= head_next;
      head_ok    <= head_ok_next;
      head_fresh <= head_fresh_next;
      if (used_we) used_mark[used_addr] <= used_val;
    end
  end

  // Request capture and registered memory reads.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rq_type    <= req_t'(req_type);
      rq_index   <= slot_index;
      rq_payload <= payload;
      link_rd    <= link_mem[head];
      pay_rd     <= pay_mem[slot_index];
      used_rd    <= used_mark[slot_index];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && link_we) begin
      link_mem[rq_index] <= '{fresh: head_fresh, ok: head_ok, idx: head};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && pay_we) begin
      pay_mem[head] <= rq_payload;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status         <= res_status;
      slot_index_out <= res_index;
      payload_out    <= res_payload;
      slot_used      <= res_used;
      table_full     <= !head_ok_next;
    end
  end

endmodule

// ===== src/slot_free_list_allocator.sv =====
// Top level of the slot free-list allocator.
// Order: the edge that accepts a request does the registered memory reads, then a commit applies
// the request and loads its response; the commit waits while the response register is stalled.
// Only one transaction is in progress at a time; a new request is taken while a response waits.
// Reset: synchronous and active high; it restores 256 free slots and needs no clearing pass,
// so requests are accepted as soon as reset is released.
module slot_free_list_allocator #(
  parameter int PAYLOAD_BITS = sfla_pkg::PAYLOAD_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: a write rebuilds the free list as 0, 1, ... n-1.
  input  logic                            active_slots_we,
  input  logic [sfla_pkg::COUNT_BITS-1:0] active_slots_wdata,
  // Request channel.
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [1:0]                      req_type,
  input  logic [sfla_pkg::SLOT_BITS-1:0]  slot_index,
  input  logic [PAYLOAD_BITS-1:0]         payload,
  // Response channel.
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [1:0]                      status,
  output logic [sfla_pkg::SLOT_BITS-1:0]  slot_index_out,
  output logic [PAYLOAD_BITS-1:0]         payload_out,
  output logic                            slot_used,
  output logic                            table_full
);
  import sfla_pkg::*;

  // The free list is a LIFO. Slots that have never been handed out since the
  // last rebuild form an implicit chain starting at the head when the head is
  // marked fresh, so only links written by free transactions live in memory.
  // A slot's stored payload is shown only while the slot is used, which makes
  // clearing the payload memory on free or rebuild unnecessary.
  cmd_t cmd;
  sts_t sts;

  sfla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfla_datapath #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .active_slots_we    (active_slots_we),
    .active_slots_wdata (active_slots_wdata),
    .req_type           (req_type),
    .slot_index         (slot_index),
    .payload            (payload),
    .rsp_valid          (rsp_valid),
    .rsp_stall          (rsp_stall),
    .status             (status),
    .slot_index_out     (slot_index_out),
    .payload_out        (payload_out),
    .slot_used          (slot_used),
    .table_full         (table_full),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

// ===== src/sfla_checker.sv =====
// Port-level assertions for the slot free-list allocator and their bind.
module sfla_checker #(
  parameter int PAYLOAD_BITS = sfla_pkg::PAYLOAD_BITS
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_stall,
  input logic                           rsp_valid,
  input logic                           rsp_stall,
  input logic [1:0]                     status,
  input logic [sfla_pkg::SLOT_BITS-1:0] slot_index_out,
  input logic [PAYLOAD_BITS-1:0]        payload_out,
  input logic                           slot_used,
  input logic                           table_full
);
  import sfla_pkg::*;

  // A stalled response holds its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(slot_index_out)
      && $stable(payload_out) && $stable(slot_used) && $stable(table_full))
    else $error("stalled response changed");

  // One transaction at a time: the cycle after acceptance the request side stalls.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while previous one still in progress");

  // A full report leaves the table full and reports no used slot.
  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == STAT_FULL |-> table_full && !slot_used)
    else $error("full status without table_full");

  // Rejected requests report neither a used slot nor a payload.
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == STAT_RANGE || status == STAT_NOT_USED)
      |-> !slot_used && payload_out == '0)
    else $error("rejected request returned slot data");

endmodule

bind slot_free_list_allocator sfla_checker #(
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_sfla_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req_valid),
  .req_stall      (req_stall),
  .rsp_valid      (rsp_valid),
  .rsp_stall      (rsp_stall),
  .status         (status),
  .slot_index_out (slot_index_out),
  .payload_out    (payload_out),
  .slot_used      (slot_used),
  .table_full     (table_full)
);
